@@ rtl/sfcp_pkg.sv @@
// Shared types and constants for the sync frame command parser.
package sfcp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned LIMIT_W    = 15;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W = 15;

    // Body is control, V high, V low, W high, W low, checksum
    localparam int unsigned BODY_LEN   = 6;
    localparam int unsigned IDX_W      = 3;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hAA;

    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_CTRL  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT = 8'd1;

    localparam logic [BYTE_W-1:0]  SPEED_CTRL_RESET  = 8'd1;
    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET = 15'd1000;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_CSUM_BAD = 2'd1,
        ST_CTRL_BAD = 2'd2
    } status_t;

endpackage

@@ rtl/sfcp_clamp.sv @@
// Symmetric clamp of a signed speed to plus or minus a limit.
module sfcp_clamp
    import sfcp_pkg::*;
(
    input  logic signed [SPEED_W-1:0] value,
    input  logic        [LIMIT_W-1:0] limit,
    output logic signed [SPEED_W-1:0] result
);

    logic signed [SPEED_W-1:0] pos_lim;
    logic signed [SPEED_W-1:0] neg_lim;

    // limit is at most 32767, so its negation always fits
    assign pos_lim = $signed({1'b0, limit});
    assign neg_lim = -pos_lim;

    always_comb
    begin
        if (value > pos_lim)
        begin
            result = pos_lim;
        end
        else if (value < neg_lim)
        begin
            result = neg_lim;
        end
        else
        begin
            result = value;
        end
    end

endmodule

@@ rtl/sync_frame_command_parser_core.sv @@
// Latency: a result is presented the cycle after the checksum byte's request is taken.
// Throughput: one byte per cycle; a single result register follows the parser state.
// The parser takes header and body bytes while a result waits; only a checksum
// byte stalls, and only while the previous result is still held.
// Reset (rst_n low, asynchronous): hunt for the header, no result pending,
// speed_ctrl_reg = 1, speed_limit_reg = 1000.
module sync_frame_command_parser_core
    import sfcp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [BYTE_W-1:0]         rx_byte,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                frame_status,
    output logic [BYTE_W-1:0]         ctrl_byte,
    output logic signed [SPEED_W-1:0] raw_forward,
    output logic signed [SPEED_W-1:0] raw_turn,
    output logic signed [SPEED_W-1:0] forward_clamped,
    output logic signed [SPEED_W-1:0] turn_clamped,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BODY_LEN - 1);

    phase_t                    phase_reg, phase_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [BYTE_W-1:0]         sum_reg, sum_next;
    logic [BYTE_W-1:0]         frame_reg [0:BODY_LEN-2];
    logic                      store_en;
    logic                      emit;
    logic                      last_byte;
    logic                      in_take;

    logic [BYTE_W-1:0]         speed_ctrl_reg;
    logic [LIMIT_W-1:0]        speed_limit_reg;

    logic                      out_valid_reg, out_valid_next;
    status_t                   status_reg, status_next;
    logic [BYTE_W-1:0]         ctrl_reg;
    logic signed [SPEED_W-1:0] raw_fwd_reg, raw_turn_reg;
    logic signed [SPEED_W-1:0] fwd_clamp_reg, turn_clamp_reg;

    logic signed [SPEED_W-1:0] fwd_word, turn_word;
    logic signed [SPEED_W-1:0] fwd_clamp, turn_clamp;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_ctrl_reg  <= SPEED_CTRL_RESET;
            speed_limit_reg <= SPEED_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SPEED_CTRL)
            begin
                speed_ctrl_reg <= cfg_data[BYTE_W-1:0];
            end
            else if (cfg_index == REG_SPEED_LIMIT)
            begin
                speed_limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------- parser
    assign last_byte = (phase_reg == PH_BODY) && (idx_reg == LAST_IDX);
    assign in_ready  = !(last_byte && out_valid_reg && !out_ready);
    assign in_take   = in_valid && in_ready;

    assign fwd_word  = $signed({frame_reg[1], frame_reg[2]});
    assign turn_word = $signed({frame_reg[3], frame_reg[4]});

    sfcp_clamp u_fwd_clamp (
        .value  (fwd_word),
        .limit  (speed_limit_reg),
        .result (fwd_clamp)
    );

    sfcp_clamp u_turn_clamp (
        .value  (turn_word),
        .limit  (speed_limit_reg),
        .result (turn_clamp)
    );

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        store_en   = 1'b0;
        emit       = 1'b0;
        if (in_take)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (rx_byte == HDR_FIRST)
                    begin
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2:
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        phase_next = PH_BODY;
                        idx_next   = '0;
                        sum_next   = '0;
                    end
                    else if (rx_byte != HDR_FIRST)
                    begin
                        phase_next = PH_HUNT1;
                        idx_next   = '0;
                    end
                end
                PH_BODY:
                begin
                    if (idx_reg < LAST_IDX)
                    begin
                        store_en = 1'b1;
                        sum_next = sum_reg + rx_byte;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                    else
                    begin
                        // checksum byte completes the frame; beyond it is unreachable
                        emit       = (idx_reg == LAST_IDX);
                        phase_next = PH_HUNT1;
                        idx_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                    idx_next   = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (sum_reg != rx_byte)
        begin
            status_next = ST_CSUM_BAD;
        end
        else if (frame_reg[0] != speed_ctrl_reg)
        begin
            status_next = ST_CTRL_BAD;
        end
        else
        begin
            status_next = ST_ACCEPTED;
        end
    end

    assign out_valid_next = emit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT1;
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (store_en)
            begin
                frame_reg[idx_reg] <= rx_byte;
            end
            if (emit)
            begin
                status_reg     <= status_next;
                ctrl_reg       <= frame_reg[0];
                raw_fwd_reg    <= fwd_word;
                raw_turn_reg   <= turn_word;
                fwd_clamp_reg  <= fwd_clamp;
                turn_clamp_reg <= turn_clamp;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_status    = status_reg;
    assign ctrl_byte       = ctrl_reg;
    assign raw_forward     = raw_fwd_reg;
    assign raw_turn        = raw_turn_reg;
    assign forward_clamped = fwd_clamp_reg;
    assign turn_clamped    = turn_clamp_reg;

`ifndef ASSERT_OFF
    // a checksum byte is never taken while the held result would be overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && last_byte) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    // completed frame always yields a result next cycle
    a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && last_byte) |=> out_valid_reg)
        else $error("completed frame gave no result");

    // body index only moves while collecting
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_BODY) |-> (idx_reg == '0))
        else $error("body index set outside collection");

    // a result never appears without a completed frame
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> ($past(in_take) && $past(last_byte)))
        else $error("result without completed frame");
`endif

endmodule

@@ tb/sv/tb_sync_frame_command_parser_core.sv @@
// Self-checking testbench for the sync frame command parser: header hunt, checksum, clamping.
`timescale 1ns / 100ps

module tb_sync_frame_command_parser_core;
    import sfcp_pkg::*;

    localparam int STALL_LIMIT        = 2000;
    localparam int DRAIN_CYCLES       = 4;
    localparam int FRAMES_PER_PHASE   = 19;
    localparam int FRAMES_PER_SETTING = 8;

    // indexes past the register list; writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE     = REG_SPEED_LIMIT + 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_TOP = 8'hFF;

    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        COLLECT_BODY
    } parse_phase_t;

    typedef struct {
        status_t                   status;
        logic [BYTE_W-1:0]         ctrl;
        logic signed [SPEED_W-1:0] fwd_raw;
        logic signed [SPEED_W-1:0] turn_raw;
        logic signed [SPEED_W-1:0] fwd_lim;
        logic signed [SPEED_W-1:0] turn_lim;
    } frame_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [BYTE_W-1:0]         rx_byte = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [1:0]                frame_status;
    logic [BYTE_W-1:0]         ctrl_byte;
    logic signed [SPEED_W-1:0] raw_forward;
    logic signed [SPEED_W-1:0] raw_turn;
    logic signed [SPEED_W-1:0] forward_clamped;
    logic signed [SPEED_W-1:0] turn_clamped;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    // parser copy kept by the testbench
    logic [BYTE_W-1:0]  ctrl_code_m = SPEED_CTRL_RESET;
    logic [LIMIT_W-1:0] limit_m     = SPEED_LIMIT_RESET;
    parse_phase_t       phase_m     = HUNT_FIRST;
    int unsigned        body_cnt    = 0;
    logic [BYTE_W-1:0]  body_buf [0:BODY_LEN-1];

    frame_result_t pending_frames [$];
    int            mismatch_count = 0;
    int            stall_cycles   = 0;
    int unsigned   in_gap_pct     = 37;
    int unsigned   out_stall_pct  = 83;

    sync_frame_command_parser_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_status    (frame_status),
        .ctrl_byte       (ctrl_byte),
        .raw_forward     (raw_forward),
        .raw_turn        (raw_turn),
        .forward_clamped (forward_clamped),
        .turn_clamped    (turn_clamped),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [SPEED_W-1:0] v,
        input logic [LIMIT_W-1:0]        lim
    );
        int vi;
        int li;
        vi = int'(v);
        li = int'(lim);
        if (vi > li)
            vi = li;
        else if (vi < -li)
            vi = -li;
        return vi[SPEED_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic apply_reg_write(
        input logic [CFG_INDEX_W-1:0] idx,
        input logic [CFG_DATA_W-1:0]  data
    );
        case (idx)
            REG_SPEED_CTRL:  ctrl_code_m = data[BYTE_W-1:0];
            REG_SPEED_LIMIT: limit_m = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_rx_byte(input logic [BYTE_W-1:0] b);
        frame_result_t     r;
        logic [BYTE_W-1:0] csum;
        case (phase_m)
            HUNT_FIRST:
                if (b == HDR_FIRST)
                    phase_m = HUNT_SECOND;
            HUNT_SECOND:
                if (b == HDR_SECOND)
                begin
                    phase_m = COLLECT_BODY;
                    body_cnt = 0;
                end
                else if (b != HDR_FIRST)
                begin
                    phase_m = HUNT_FIRST;
                end
            default:
            begin
                body_buf[body_cnt] = b;
                body_cnt++;
                if (body_cnt == BODY_LEN)
                begin
                    csum = body_buf[0] + body_buf[1] + body_buf[2] + body_buf[3] + body_buf[4];
                    if (csum != body_buf[5])
                        r.status = ST_CSUM_BAD;
                    else if (body_buf[0] != ctrl_code_m)
                        r.status = ST_CTRL_BAD;
                    else
                        r.status = ST_ACCEPTED;
                    r.ctrl = body_buf[0];
                    r.fwd_raw = {body_buf[1], body_buf[2]};
                    r.turn_raw = {body_buf[3], body_buf[4]};
                    r.fwd_lim = clamp_speed(r.fwd_raw, limit_m);
                    r.turn_lim = clamp_speed(r.turn_raw, limit_m);
                    pending_frames.push_back(r);
                    phase_m = HUNT_FIRST;
                    body_cnt = 0;
                end
            end
        endcase
    endtask

    task automatic compare_frame_result();
        frame_result_t want;
        if (pending_frames.size() == 0)
        begin
            report_mismatch("result with no frame pending");
            return;
        end
        want = pending_frames.pop_front();
        if (frame_status !== want.status)
            report_mismatch($sformatf("frame_status got %0d want %0d", frame_status, want.status));
        if (ctrl_byte !== want.ctrl)
            report_mismatch($sformatf("ctrl_byte got %02h want %02h", ctrl_byte, want.ctrl));
        if (raw_forward !== want.fwd_raw)
            report_mismatch($sformatf("raw_forward got %0d want %0d", raw_forward, want.fwd_raw));
        if (raw_turn !== want.turn_raw)
            report_mismatch($sformatf("raw_turn got %0d want %0d", raw_turn, want.turn_raw));
        if (forward_clamped !== want.fwd_lim)
            report_mismatch($sformatf("forward_clamped got %0d want %0d",
                                      forward_clamped, want.fwd_lim));
        if (turn_clamped !== want.turn_lim)
            report_mismatch($sformatf("turn_clamped got %0d want %0d", turn_clamped, want.turn_lim));
    endtask

    // all requests sampled on pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
            if (in_valid && in_ready)
                predict_rx_byte(rx_byte);
            if (out_valid && out_ready)
                compare_frame_result();
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("sync_frame_command_parser_core test failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_gap_pct);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_frame(
        input logic [BYTE_W-1:0]  ctrl,
        input logic [SPEED_W-1:0] v,
        input logic [SPEED_W-1:0] w,
        input logic [BYTE_W-1:0]  csum_err
    );
        logic [BYTE_W-1:0] csum;
        csum = ctrl + v[15:8] + v[7:0] + w[15:8] + w[7:0] + csum_err;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(ctrl);
        send_byte(v[15:8]);
        send_byte(v[7:0]);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
        send_byte(csum);
    endtask

    task automatic write_reg(
        input logic [CFG_INDEX_W-1:0] idx,
        input logic [CFG_DATA_W-1:0]  data
    );
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // registers only change with no frame in flight
    task automatic wait_drained();
        in_valid <= 1'b0;
        // let the checker see the last request before looking at the queue
        @(posedge clk);
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SPEED_W-1:0] pick_speed();
        logic [SPEED_W-1:0] lim16;
        lim16 = {1'b0, limit_m};
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return lim16;
            3: return -lim16;
            4: return lim16 + 16'd1;
            5: return -(lim16 + 16'd1);
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic reconfigure_random();
        logic [BYTE_W-1:0]  code;
        logic [LIMIT_W-1:0] lim;
        case ($urandom_range(3))
            0: code = 8'h00;
            1: code = 8'hFF;
            2: code = SPEED_CTRL_RESET;
            default: code = 8'($urandom_range(255));
        endcase
        case ($urandom_range(4))
            0: lim = '0;
            1: lim = 15'h7FFF;
            2: lim = 15'd1;
            3: lim = SPEED_LIMIT_RESET;
            default: lim = 15'($urandom_range(15'h7FFF));
        endcase
        wait_drained();
        // upper data bits are don't-care for the control code
        write_reg(REG_SPEED_CTRL, {7'($urandom_range(127)), code});
        write_reg(REG_SPEED_LIMIT, lim);
    endtask

    task automatic send_random_frame();
        int unsigned       roll;
        logic [BYTE_W-1:0] ctrl;
        logic [BYTE_W-1:0] err;
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            // line noise, may leave a partial header or start a bogus body
            repeat ($urandom_range(1, 5))
                send_byte(($urandom_range(2) == 0) ? HDR_FIRST : 8'($urandom_range(255)));
        end
        else if (roll < 25)
        begin
            send_byte(HDR_FIRST);
            send_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(4) == 0)
            send_byte(HDR_FIRST);
        ctrl = ($urandom_range(1) == 0) ? ctrl_code_m : 8'($urandom_range(255));
        err = ($urandom_range(4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        send_frame(ctrl, pick_speed(), pick_speed(), err);
    endtask

    task automatic test_header_and_status();
        // repeated first header byte keeps waiting for the second
        send_byte(HDR_FIRST);
        send_frame(SPEED_CTRL_RESET, 16'h7FFF, 16'h8000, 8'h00);
        // stray second header byte, then a broken header, restart the hunt
        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
        send_byte(8'h12);
        send_frame(SPEED_CTRL_RESET, 16'd1000, -16'sd1001, 8'h01);
        // good checksum, unsupported control byte
        send_frame(8'h02, 16'h0001, -16'sd1000, 8'h00);
    endtask

    task automatic test_register_extremes();
        wait_drained();
        write_reg(REG_SPEED_CTRL, 15'h7F00);
        write_reg(REG_SPEED_LIMIT, 15'd0);
        write_reg(REG_SPARE, 15'h7FFF);
        write_reg(REG_SPARE_TOP, 15'h7FFF);
        // zero limit, code zero; spare writes must not disturb either
        send_frame(8'h00, 16'h8000, 16'h7FFF, 8'h00);
        wait_drained();
        write_reg(REG_SPEED_CTRL, 15'h00FF);
        write_reg(REG_SPEED_LIMIT, 15'h7FFF);
        // most negative speed clamps to -32767
        send_frame(8'hFF, 16'h8000, 16'h7FFF, 8'h00);
    endtask

    task automatic test_random_traffic(input int unsigned in_pct, input int unsigned out_pct);
        in_gap_pct = in_pct;
        out_stall_pct = out_pct;
        for (int i = 0; i < FRAMES_PER_PHASE; i++)
        begin
            if (i % FRAMES_PER_SETTING == 0)
                reconfigure_random();
            send_random_frame();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_and_status();
        test_register_extremes();
        test_random_traffic(37, 83);
        test_random_traffic(83, 37);
        test_random_traffic(0, 0);

        wait_drained();
        if (mismatch_count == 0)
            $display("sync_frame_command_parser_core test passed");
        else
            $display("sync_frame_command_parser_core test failed");
        $finish;
    end

endmodule

@@ sync_frame_command_parser_core.f @@
rtl/sfcp_pkg.sv
rtl/sfcp_clamp.sv
rtl/sync_frame_command_parser_core.sv
tb/sv/tb_sync_frame_command_parser_core.sv
